>>> hw/rtl/msrs_pkg.sv
// Shared types, codes and compare functions for the multi-key sorted range search.
package msrs_pkg;

    // Default sizing of the row table.
    localparam int DEF_ROWS = 64;
    localparam int DEF_KEYS = 4;

    // Key columns carried by one input item.
    localparam int INPUT_COLS = 4;

    // Width of row indexes, bounds and counts.
    localparam int IW = 7;

    // Column type codes.
    localparam logic [2:0] TYPE_S32 = 3'd0;
    localparam logic [2:0] TYPE_S64 = 3'd1;
    localparam logic [2:0] TYPE_U32 = 3'd2;
    localparam logic [2:0] TYPE_F32 = 3'd3;
    localparam logic [2:0] TYPE_F64 = 3'd4;
    localparam logic [2:0] TYPE_TID = 3'd5;

    // Compare result codes.
    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;
    localparam logic [1:0] CMP_UN = 2'd3;

    // Column flag codes.
    localparam logic [1:0] FLAG_COMPARE = 2'd0;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NUM_KEYS  = 2'd0;
    localparam logic [1:0] CFG_COL_TYPES = 2'd1;
    localparam logic [1:0] CFG_DESC_MASK = 2'd2;

    typedef logic [1:0] cmp_t;

    // Unsigned three-way compare.
    function automatic cmp_t ucmp(logic [63:0] a, logic [63:0] b);
        cmp_t r;
        if (a < b) r = CMP_LT;
        else if (a > b) r = CMP_GT;
        else r = CMP_EQ;
        return r;
    endfunction

    // IEEE compare on raw bits; NaN is unordered, both zeros are equal.
    function automatic cmp_t float_cmp(logic [63:0] a_in, logic [63:0] b_in, logic is64);
        logic [63:0] all;
        logic [63:0] sgn;
        logic [63:0] expm;
        logic [63:0] absm;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] ka;
        logic [63:0] kb;
        cmp_t r;
        all  = is64 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        sgn  = is64 ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
        expm = is64 ? 64'h7FF0_0000_0000_0000 : 64'h0000_0000_7F80_0000;
        absm = all & ~sgn;
        a = a_in & all;
        b = b_in & all;
        if ((a & absm) > expm || (b & absm) > expm) begin
            r = CMP_UN;
        end
        else begin
            if ((a & absm) == 64'd0) a = 64'd0;
            if ((b & absm) == 64'd0) b = 64'd0;
            ka = ((a & sgn) != 64'd0) ? (~a & all) : (a | sgn);
            kb = ((b & sgn) != 64'd0) ? (~b & all) : (b | sgn);
            r = ucmp(ka, kb);
        end
        return r;
    endfunction

    // Compare a stored value against a key for one column type.
    function automatic cmp_t col_cmp(logic [2:0] ctype, logic [63:0] v, logic [63:0] k);
        cmp_t r;
        case (ctype)
            TYPE_S32: r = ucmp({32'd0, v[31:0] ^ 32'h8000_0000},
                               {32'd0, k[31:0] ^ 32'h8000_0000});
            TYPE_S64: r = ucmp(v ^ 64'h8000_0000_0000_0000, k ^ 64'h8000_0000_0000_0000);
            TYPE_U32: r = ucmp({32'd0, v[31:0]}, {32'd0, k[31:0]});
            TYPE_F32: r = float_cmp(v, k, 1'b0);
            TYPE_F64: r = float_cmp(v, k, 1'b1);
            TYPE_TID: r = ucmp({16'd0, v[47:0]}, {16'd0, k[47:0]});
            default:  r = ucmp(v, k);
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/multikey_sorted_range_search_top.sv
// Top level of the multi-key sorted range search: config, sequencer and lane merge.
// A row write goes to the done state, then the result register is loaded.
// A search takes the columns in order: a pinned column moves one window bound onto the other,
// and a compared column scans the rows of its window, reading one row per cycle.
// One item is in work at a time; the next transfer waits until the result register is loaded.
// Reset (rst_n low, async): num_keys 1, other config and control cleared; data, table undefined.
module multikey_sorted_range_search_top
    import msrs_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int KEYS = DEF_KEYS
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [11:0]    cfg_data,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           mode,
    input  logic [5:0]     row_index,
    input  logic [6:0]     row_count,
    input  logic [63:0]    key_col0,
    input  logic [63:0]    key_col1,
    input  logic [63:0]    key_col2,
    input  logic [63:0]    key_col3,
    input  logic [7:0]     column_flags,
    input  logic           inclusive,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [IW-1:0]  found_index,
    output logic           status
);

    localparam int AW = $clog2(ROWS);
    localparam int NLANES = (KEYS < INPUT_COLS) ? KEYS : INPUT_COLS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_COL  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [2:0]    num_keys_reg;
    logic [11:0]   col_types_reg;
    logic [3:0]    desc_mask_reg;
    logic [1:0]    state_reg, state_next;
    logic [2:0]    col_reg, col_next;
    logic [IW-1:0] lower_reg, lower_next;
    logic [IW-1:0] upper_reg, upper_next;
    logic [IW-1:0] ptr_reg, ptr_next;
    logic [IW-1:0] pidx_reg, pidx_next;
    logic          lset_reg, lset_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] rc_reg, rc_next;
    logic [7:0]    flags_reg, flags_next;
    logic          incl_reg, incl_next;
    logic [IW-1:0] res_idx_reg, res_idx_next;
    logic          res_st_reg, res_st_next;
    logic          out_valid_reg, out_valid_next;
    logic [IW-1:0] found_reg, found_next;
    logic          status_reg, status_next;
    logic [63:0]   key_reg [INPUT_COLS];
    logic [63:0]   key_in  [INPUT_COLS];
    cmp_t          lane_cmp [INPUT_COLS];
    logic          rd_en;
    logic [2:0]    ncols;
    logic          accept;
    logic          wr_en;
    cmp_t          cur_cmp;
    logic          beyond;
    logic [1:0]    cur_flag;

    assign key_in[0] = key_col0;
    assign key_in[1] = key_col1;
    assign key_in[2] = key_col2;
    assign key_in[3] = key_col3;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign wr_en    = accept && !mode && (int'(row_index) < ROWS);
    assign ncols    = (int'(num_keys_reg) > NLANES) ? 3'(NLANES) : num_keys_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_keys_reg  <= 3'd1;
            col_types_reg <= 12'd0;
            desc_mask_reg <= 4'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_KEYS:  num_keys_reg  <= cfg_data[2:0];
                CFG_COL_TYPES: col_types_reg <= cfg_data;
                CFG_DESC_MASK: desc_mask_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Search keys are captured with the transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < INPUT_COLS; i++)
            begin
                key_reg[i] <= key_in[i];
            end
        end
    end

    // Column lanes; missing lanes never get selected.
    for (genvar g = 0; g < INPUT_COLS; g++)
    begin : g_lane
        if (g < NLANES)
        begin : g_on
            msrs_lane #(.ROWS(ROWS)) u_lane
            (
                .clk   (clk),
                .we    (wr_en),
                .waddr (AW'(row_index)),
                .wdata (key_in[g]),
                .re    (rd_en),
                .raddr (AW'(ptr_reg)),
                .ctype (col_types_reg[3*g +: 3]),
                .key   (key_reg[g]),
                .cmp   (lane_cmp[g])
            );
        end
        else
        begin : g_off
            assign lane_cmp[g] = CMP_EQ;
        end
    end

    // Merge: pick the active column's comparison.
    assign cur_cmp  = lane_cmp[col_reg[1:0]];
    assign beyond   = desc_mask_reg[col_reg[1:0]] ? (cur_cmp == CMP_LT) : (cur_cmp == CMP_GT);
    assign cur_flag = flags_reg[2*col_reg[1:0] +: 2];
    assign rd_en    = (state_reg == ST_SCAN) && !(pend_reg && beyond) && (ptr_reg < upper_reg);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        ptr_next       = ptr_reg;
        pidx_next      = pidx_reg;
        lset_next      = lset_reg;
        pend_next      = pend_reg;
        rc_next        = rc_reg;
        flags_next     = flags_reg;
        incl_next      = incl_reg;
        res_idx_next   = res_idx_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        status_next    = status_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    flags_next = column_flags;
                    incl_next  = inclusive;
                    col_next   = 3'd0;
                    lower_next = '0;
                    if (!mode)
                    begin
                        res_idx_next = {1'b0, row_index};
                        res_st_next  = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        rc_next    = (int'(row_count) > ROWS) ? IW'(ROWS) : row_count;
                        upper_next = rc_next;
                        state_next = ST_COL;
                    end
                end
            end
            ST_COL:
            begin
                if (lower_reg < upper_reg && col_reg < ncols)
                begin
                    if (cur_flag == FLAG_COMPARE)
                    begin
                        ptr_next   = lower_reg;
                        lset_next  = 1'b0;
                        pend_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        if (cur_flag[0]) upper_next = lower_reg;
                        else lower_next = upper_reg;
                        col_next = col_reg + 3'd1;
                    end
                end
                else
                begin
                    res_idx_next = incl_reg ? lower_reg : upper_reg;
                    res_st_next  = (res_idx_next >= rc_reg);
                    state_next   = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && beyond)
                begin
                    // First row beyond the key closes the window.
                    if (!lset_reg) lower_next = pidx_reg;
                    upper_next = pidx_reg;
                    pend_next  = 1'b0;
                    col_next   = col_reg + 3'd1;
                    state_next = ST_COL;
                end
                else if (!pend_reg && ptr_reg >= upper_reg)
                begin
                    // Window exhausted.
                    if (!lset_reg) lower_next = upper_reg;
                    col_next   = col_reg + 3'd1;
                    state_next = ST_COL;
                end
                else
                begin
                    if (pend_reg && cur_cmp == CMP_EQ && !lset_reg)
                    begin
                        lower_next = pidx_reg;
                        lset_next  = 1'b1;
                    end
                    pend_next = rd_en;
                    if (rd_en)
                    begin
                        pidx_next = ptr_reg;
                        ptr_next  = ptr_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_idx_reg;
                    status_next    = res_st_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        lower_reg   <= lower_next;
        upper_reg   <= upper_next;
        ptr_reg     <= ptr_next;
        pidx_reg    <= pidx_next;
        lset_reg    <= lset_next;
        rc_reg      <= rc_next;
        flags_reg   <= flags_next;
        incl_reg    <= incl_next;
        res_idx_reg <= res_idx_next;
        res_st_reg  <= res_st_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign found_index = found_reg;
    assign status      = status_reg;

endmodule

>>> hw/rtl/msrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msrs_ram
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/msrs_lane.sv
// One key column lane: column storage and the typed comparator.
module msrs_lane
    import msrs_pkg::*;
#(
    parameter int ROWS = DEF_ROWS
)
(
    input  logic                    clk,
    input  logic                    we,
    input  logic [$clog2(ROWS)-1:0] waddr,
    input  logic [63:0]             wdata,
    input  logic                    re,
    input  logic [$clog2(ROWS)-1:0] raddr,
    input  logic [2:0]              ctype,
    input  logic [63:0]             key,
    output cmp_t                    cmp
);

    logic [63:0] rdata;

    // Column storage, one row per entry.
    msrs_ram #(.WIDTH(64), .DEPTH(ROWS)) u_ram
    (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Compare the row just read against the search key.
    assign cmp = col_cmp(ctype, rdata, key);

endmodule

>>> hw/rtl/msrs_chk.sv
// Port-level checker for the multi-key sorted range search, bound to the top level.
module msrs_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] found_index,
    input logic       status
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found_index) && $stable(status))
        else $error("result changed while stalled");

    // Only one item is in work: an input transfer makes the block busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

    // No index is ever past the largest row count.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> found_index <= 7'd64)
        else $error("found index out of range");

endmodule

bind multikey_sorted_range_search_top msrs_chk u_msrs_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found_index (found_index),
    .status      (status)
);
